FILE: sv/plti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plti_pkg
// Shared types, codes and helpers of the piecewise linear table interpolator:
// the table entry layout, controller states, and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package plti_pkg;

  // Default number of table entries.
  localparam int PLTI_TABLE_DEPTH = 64;

  // Field widths fixed by the interface.
  localparam int KEY_W   = 24;
  localparam int VAL_W   = 32;
  localparam int CNT_W   = 7;
  localparam int IDX_W   = 6;
  localparam int COL_W   = 2;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int QUO_W   = 32;
  localparam int DIVC_W  = 5;

  // Operation codes of an input transaction.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Column codes of a lookup.
  localparam logic [COL_W-1:0] COL_FVF  = 2'd0;
  localparam logic [COL_W-1:0] COL_GOR  = 2'd1;
  localparam logic [COL_W-1:0] COL_VISC = 2'd2;
  localparam logic [COL_W-1:0] COL_ZFAC = 2'd3;

  // Register index of the entry count (paddr[2]).
  localparam logic REG_ENTRY_COUNT = 1'b0;

  // One table row: key and its four property values.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] fvf;
    logic [VAL_W-1:0] gor;
    logic [VAL_W-1:0] visc;
    logic [VAL_W-1:0] zfac;
  } entry_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_CHK_FIRST,
    ST_CHK_LAST,
    ST_SEARCH,
    ST_CHK_MID,
    ST_MUL,
    ST_ABS,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_entry;
    logic start;
    logic rd_first;
    logic rd_last;
    logic rd_mid;
    logic save_lo;
    logic save_hi;
    logic step;
    logic res_zero;
    logic res_rd;
    logic res_vlo;
    logic mul;
    logic abs_load;
    logic div_step;
    logic res_interp;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic p_le_key;
    logic p_ge_key;
    logic gap_gt1;
    logic dx_bad;
    logic div_last;
    logic out_free;
  } sts_t;

  // Select the value column of a table row.
  function automatic logic [VAL_W-1:0] col_value(input entry_t e,
                                                  input logic [COL_W-1:0] col);
    logic [VAL_W-1:0] v;
    unique case (col)
      COL_FVF:  v = e.fvf;
      COL_GOR:  v = e.gor;
      COL_VISC: v = e.visc;
      COL_ZFAC: v = e.zfac;
      default:  v = e.zfac;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/piecewise_linear_table_interpolator_core.sv
`timescale 1ns / 1ps
// Write transaction: the next transaction is accepted in the next cycle.
// Lookup: end checks and a binary search (at most 6 steps for 64 entries) on the
// single table read port, the multiply and the bit-serial divide, then output;
// an empty table, a clamp to the first or last entry, or non-ascending bracketing
// keys skip to output. Input reopens in the cycle after the result is loaded.
// Sync reset (rst_n low) clears only entry count, FSM state, divider count and out_valid.
// ----------------------------------------------------------------------------
// piecewise_linear_table_interpolator_core
// Piecewise linear interpolation table: stores ascending pressure keys with
// four property values and answers clamped, interpolated column lookups.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interpolator_core
  import plti_pkg::*;
#(
  parameter int TABLE_DEPTH = PLTI_TABLE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  // Input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_opcode,
  input  logic [IDX_W-1:0]    in_entry_index,
  input  logic [KEY_W-1:0]    in_pressure,
  input  logic [COL_W-1:0]    in_column_select,
  input  logic [VAL_W-1:0]    in_fvf_value,
  input  logic [VAL_W-1:0]    in_gor_value,
  input  logic [VAL_W-1:0]    in_visc_value,
  input  logic [VAL_W-1:0]    in_zfac_value,
  // Result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [VAL_W-1:0]    out_result_value,
  // Configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  plti_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Table, arithmetic and output register.
  plti_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_entry_index   (in_entry_index),
    .in_pressure      (in_pressure),
    .in_column_select (in_column_select),
    .in_fvf_value     (in_fvf_value),
    .in_gor_value     (in_gor_value),
    .in_visc_value    (in_visc_value),
    .in_zfac_value    (in_zfac_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule

FILE: sv/plti_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plti_ctrl
// Sequencer of the interpolator. Takes input transactions, walks a lookup
// through the end checks, the binary search, the multiply and the divide,
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module plti_ctrl
  import plti_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_opcode,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_opcode == OP_LOOKUP) begin
          state_nxt = ST_FIRST;
        end
      end
      ST_FIRST: begin
        state_nxt = sts.empty ? ST_OUT : ST_CHK_FIRST;
      end
      ST_CHK_FIRST: begin
        state_nxt = sts.p_le_key ? ST_OUT : ST_CHK_LAST;
      end
      ST_CHK_LAST: begin
        state_nxt = sts.p_ge_key ? ST_OUT : ST_SEARCH;
      end
      ST_SEARCH: begin
        state_nxt = sts.gap_gt1 ? ST_CHK_MID : ST_MUL;
      end
      ST_CHK_MID: begin
        state_nxt = ST_SEARCH;
      end
      ST_MUL: begin
        state_nxt = sts.dx_bad ? ST_OUT : ST_ABS;
      end
      ST_ABS: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Commands for the datapath.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.wr_entry = in_valid && in_opcode == OP_WRITE;
        cmd.start    = in_valid && in_opcode == OP_LOOKUP;
      end
      ST_FIRST: begin
        cmd.res_zero = sts.empty;
        cmd.rd_first = !sts.empty;
      end
      ST_CHK_FIRST: begin
        cmd.res_rd  = sts.p_le_key;
        cmd.save_lo = !sts.p_le_key;
        cmd.rd_last = !sts.p_le_key;
      end
      ST_CHK_LAST: begin
        cmd.res_rd  = sts.p_ge_key;
        cmd.save_hi = !sts.p_ge_key;
      end
      ST_SEARCH: begin
        cmd.rd_mid = sts.gap_gt1;
      end
      ST_CHK_MID: begin
        cmd.step = 1'b1;
      end
      ST_MUL: begin
        cmd.res_vlo = sts.dx_bad;
        cmd.mul     = !sts.dx_bad;
      end
      ST_ABS: begin
        cmd.abs_load = 1'b1;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_FIN: begin
        cmd.res_interp = 1'b1;
      end
      ST_OUT: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: sv/plti_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plti_datapath
// Table memory, entry count register, search indices, bracketing entries,
// multiplier, bit-serial divider and the output register of the interpolator.
// ----------------------------------------------------------------------------
module plti_datapath
  import plti_pkg::*;
#(
  parameter int TABLE_DEPTH = PLTI_TABLE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  // Input payload
  input  logic [IDX_W-1:0]    in_entry_index,
  input  logic [KEY_W-1:0]    in_pressure,
  input  logic [COL_W-1:0]    in_column_select,
  input  logic [VAL_W-1:0]    in_fvf_value,
  input  logic [VAL_W-1:0]    in_gor_value,
  input  logic [VAL_W-1:0]    in_visc_value,
  input  logic [VAL_W-1:0]    in_zfac_value,
  // Result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [VAL_W-1:0]    out_result_value,
  // Configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  // Controller link
  input  cmd_t                cmd,
  output sts_t                sts
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // Table memory and its registered read port.
  entry_t         mem [TABLE_DEPTH];
  entry_t         rd_q_r;
  logic [AW-1:0]  rd_addr;
  logic           rd_en;

  // Lookup context.
  logic [CNT_W-1:0] count_r;
  logic [CW-1:0]    n_nxt;
  logic [CW-1:0]    n_r;
  logic [KEY_W-1:0] p_r;
  logic [COL_W-1:0] col_r;
  logic [AW-1:0]    lo_r;
  logic [AW-1:0]    hi_r;
  logic [AW-1:0]    mid;
  logic [KEY_W-1:0] klo_r;
  logic [KEY_W-1:0] khi_r;
  logic [VAL_W-1:0] vlo_r;
  logic [VAL_W-1:0] vhi_r;
  logic [VAL_W-1:0] rd_val;

  // Arithmetic.
  logic signed [VAL_W:0]           dv;
  logic signed [KEY_W:0]           dpx;
  logic signed [VAL_W+KEY_W+1:0]   prod_r;
  logic        [VAL_W+KEY_W+1:0]   mag;
  logic        [KEY_W-1:0]         dx_r;
  logic        [KEY_W-1:0]         rem_r;
  logic        [KEY_W-1:0]         rem_nxt;
  logic        [QUO_W-1:0]         quo_r;
  logic        [QUO_W-1:0]         quo_nxt;
  logic        [KEY_W:0]           trial;
  logic                            trial_ge;
  logic                            neg_r;
  logic        [DIVC_W-1:0]        cnt_r;
  logic        [VAL_W-1:0]         res_r;
  logic        [VAL_W-1:0]         out_value_r;
  logic                            out_valid_r;

  // Entry count register on the configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == REG_ENTRY_COUNT) begin
      count_r <= pwdata[CNT_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ENTRY_COUNT) ? PDATA_W'(count_r) : '0;

  // Entries in use, saturated to the table depth.
  assign n_nxt = (32'(count_r) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(count_r);

  // Read address selection.
  assign mid     = AW'(({1'b0, lo_r} + {1'b0, hi_r}) >> 1);
  assign rd_en   = cmd.rd_first | cmd.rd_last | cmd.rd_mid;
  always_comb begin
    rd_addr = '0;
    priority if (cmd.rd_last) begin
      rd_addr = hi_r;
    end else if (cmd.rd_mid) begin
      rd_addr = mid;
    end else begin
      rd_addr = '0;
    end
  end

  // Table memory: written on a write transaction, read one row per cycle.
  always_ff @(posedge clk) begin
    if (cmd.wr_entry && (32'(in_entry_index) < 32'(TABLE_DEPTH))) begin
      mem[AW'(in_entry_index)] <= '{key:  in_pressure,
                                    fvf:  in_fvf_value,
                                    gor:  in_gor_value,
                                    visc: in_visc_value,
                                    zfac: in_zfac_value};
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  assign rd_val = col_value(rd_q_r, col_r);

  // Query context and search bounds.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      p_r   <= in_pressure;
      col_r <= in_column_select;
      n_r   <= n_nxt;
      lo_r  <= '0;
      hi_r  <= AW'(n_nxt - CW'(1));
    end
    if (cmd.save_lo) begin
      klo_r <= rd_q_r.key;
      vlo_r <= rd_val;
    end
    if (cmd.save_hi) begin
      khi_r <= rd_q_r.key;
      vhi_r <= rd_val;
    end
    // One binary search step on the row read at the midpoint.
    if (cmd.step) begin
      if (p_r >= rd_q_r.key) begin
        lo_r  <= mid;
        klo_r <= rd_q_r.key;
        vlo_r <= rd_val;
      end else begin
        hi_r  <= mid;
        khi_r <= rd_q_r.key;
        vhi_r <= rd_val;
      end
    end
  end

  // Product of the value step and the pressure offset.
  assign dv  = $signed({vhi_r[VAL_W-1], vhi_r}) - $signed({vlo_r[VAL_W-1], vlo_r});
  assign dpx = $signed({1'b0, p_r - klo_r});

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= dv * dpx;
      dx_r   <= khi_r - klo_r;
    end
  end

  // Restoring divider, one quotient bit per cycle. The magnitude of the
  // product is below dx * 2^32, so its upper bits already form a partial
  // remainder smaller than dx and 32 steps give the whole quotient.
  assign mag      = prod_r[VAL_W+KEY_W+1] ? (~prod_r + 1'b1) : prod_r;
  assign trial    = {rem_r, quo_r[QUO_W-1]};
  assign trial_ge = trial >= {1'b0, dx_r};
  assign rem_nxt  = trial_ge ? KEY_W'(trial - {1'b0, dx_r}) : trial[KEY_W-1:0];
  assign quo_nxt  = {quo_r[QUO_W-2:0], trial_ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.abs_load) begin
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.abs_load) begin
      rem_r <= mag[QUO_W+KEY_W-1:QUO_W];
      quo_r <= mag[QUO_W-1:0];
      neg_r <= prod_r[VAL_W+KEY_W+1];
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  // Result selection.
  always_ff @(posedge clk) begin
    priority if (cmd.res_zero) begin
      res_r <= '0;
    end else if (cmd.res_rd) begin
      res_r <= rd_val;
    end else if (cmd.res_vlo) begin
      res_r <= vlo_r;
    end else if (cmd.res_interp) begin
      res_r <= vlo_r + (neg_r ? (~quo_r + 1'b1) : quo_r);
    end else begin
      res_r <= res_r;
    end
  end

  // Output register: holds a result until the consumer takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value_r <= res_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;

  // Status for the controller.
  always_comb begin
    sts          = '0;
    sts.empty    = n_r == '0;
    sts.p_le_key = p_r <= rd_q_r.key;
    sts.p_ge_key = p_r >= rd_q_r.key;
    sts.gap_gt1  = ({1'b0, hi_r} - {1'b0, lo_r}) > (AW+1)'(1);
    sts.dx_bad   = khi_r <= klo_r;
    sts.div_last = cnt_r == DIVC_W'(QUO_W - 1);
    sts.out_free = !out_valid_r || out_ready;
  end

endmodule

FILE: bench/plti_lookup_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plti_lookup_monitor
// Watches the input, result and configuration ports of the interpolator,
// keeps its own copy of the table and the entry count, predicts every lookup
// result and compares the results in order as they leave the block.
// ----------------------------------------------------------------------------
module plti_lookup_monitor
  import plti_pkg::*;
#(
  parameter int TABLE_DEPTH = PLTI_TABLE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_opcode,
  input  logic [IDX_W-1:0]   in_entry_index,
  input  logic [KEY_W-1:0]   in_pressure,
  input  logic [COL_W-1:0]   in_column_select,
  input  logic [VAL_W-1:0]   in_fvf_value,
  input  logic [VAL_W-1:0]   in_gor_value,
  input  logic [VAL_W-1:0]   in_visc_value,
  input  logic [VAL_W-1:0]   in_zfac_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [VAL_W-1:0]   out_result_value,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic               pready,
  output int                 mismatch_count,
  output int                 outstanding_lookups
);

  localparam logic [PADDR_W-1:0] ADDR_ENTRY_COUNT = {REG_ENTRY_COUNT, 2'b00};
  localparam int MAX_REPORTS = 10;

  // Shadow of the table, one value array per column code.
  logic [KEY_W-1:0] key_tab [TABLE_DEPTH];
  logic [VAL_W-1:0] val_tab [4][TABLE_DEPTH];
  logic [CNT_W-1:0] entry_count_q;

  // Predicted lookup results, oldest first.
  logic [VAL_W-1:0] predicted_values [$];
  int errors;
  int results_seen;

  // Clamped or interpolated column value for a query pressure.
  function automatic logic [VAL_W-1:0] interpolate(input logic [COL_W-1:0] col,
                                                   input logic [KEY_W-1:0] p);
    int     n;
    int     lo;
    int     hi;
    int     mid;
    longint v_lo;
    longint v_hi;
    longint dx;
    longint dp;
    longint sum;
    n = int'(entry_count_q);
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    if (n == 0) return '0;
    if (p <= key_tab[0]) return val_tab[col][0];
    if (p >= key_tab[n-1]) return val_tab[col][n-1];
    // Binary search for the bracketing pair.
    lo = 0;
    hi = n - 1;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (p < key_tab[mid]) hi = mid;
      else lo = mid;
    end
    dx = longint'(key_tab[hi]) - longint'(key_tab[lo]);
    if (dx <= 0) return val_tab[col][lo];
    v_lo = longint'($signed(val_tab[col][lo]));
    v_hi = longint'($signed(val_tab[col][hi]));
    dp   = longint'(p) - longint'(key_tab[lo]);
    // SystemVerilog division truncates toward zero.
    sum  = v_lo + ((v_hi - v_lo) * dp) / dx;
    return sum[VAL_W-1:0];
  endfunction

  // Results are retired before new lookups are queued in the same cycle.
  always @(posedge clk) begin : monitor
    logic [VAL_W-1:0] want;
    if (!rst_n) begin
      entry_count_q = '0;
      predicted_values.delete();
    end else begin
      // Result transaction against the oldest prediction.
      if (out_valid && out_ready) begin
        results_seen++;
        if (predicted_values.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("ERROR: result %0d arrived with no lookup pending, actual %h",
                     results_seen, out_result_value);
        end else begin
          want = predicted_values.pop_front();
          if (want !== out_result_value) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("ERROR: result %0d mismatch, expected %h (%0d), actual %h (%0d)",
                       results_seen, want, $signed(want), out_result_value,
                       $signed(out_result_value));
          end
        end
      end

      // Configuration write of the entry count.
      if (psel && penable && pwrite && pready && paddr == ADDR_ENTRY_COUNT)
        entry_count_q = pwdata[CNT_W-1:0];

      // Input transaction: table write or lookup.
      if (in_valid && in_ready) begin
        if (in_opcode == OP_WRITE) begin
          if (int'(in_entry_index) < TABLE_DEPTH) begin
            key_tab[in_entry_index]           = in_pressure;
            val_tab[COL_FVF][in_entry_index]  = in_fvf_value;
            val_tab[COL_GOR][in_entry_index]  = in_gor_value;
            val_tab[COL_VISC][in_entry_index] = in_visc_value;
            val_tab[COL_ZFAC][in_entry_index] = in_zfac_value;
          end
        end else begin
          predicted_values.push_back(interpolate(in_column_select, in_pressure));
        end
      end
    end
    mismatch_count      <= errors;
    outstanding_lookups <= predicted_values.size();
  end

endmodule

FILE: bench/tb_piecewise_linear_table_interpolator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_piecewise_linear_table_interpolator_core
// Loads tables of many sizes and shapes, sets the entry count through the
// APB port and runs lookups against them with random idling on both sides.
// A separate monitor predicts and checks every result.
// ----------------------------------------------------------------------------
module tb_piecewise_linear_table_interpolator_core;
  import plti_pkg::*;

  localparam int TABLE_DEPTH      = PLTI_TABLE_DEPTH;
  localparam int TARGET_ITEMS     = 750;
  localparam int QUIET_AFTER      = 640;
  localparam int SETTLE_CYCLES    = 64;
  localparam int LONG_HOLD_CYCLES = 500;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int KEY_MAX          = 24'hFFFFFF;
  localparam logic [PADDR_W-1:0] ADDR_ENTRY_COUNT = {REG_ENTRY_COUNT, 2'b00};

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_opcode;
  logic [IDX_W-1:0]   in_entry_index;
  logic [KEY_W-1:0]   in_pressure;
  logic [COL_W-1:0]   in_column_select;
  logic [VAL_W-1:0]   in_fvf_value;
  logic [VAL_W-1:0]   in_gor_value;
  logic [VAL_W-1:0]   in_visc_value;
  logic [VAL_W-1:0]   in_zfac_value;
  logic               out_valid;
  logic               out_ready;
  logic [VAL_W-1:0]   out_result_value;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int mismatch_count;
  int outstanding_lookups;

  // Stimulus bookkeeping.
  bit         idle_en;
  int         hold_requests;
  int         items_sent;
  int         writes_sent;
  int         lookups_sent;
  int         settings_made;
  int         tbl_key [TABLE_DEPTH];

  piecewise_linear_table_interpolator_core #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_entry_index   (in_entry_index),
    .in_pressure      (in_pressure),
    .in_column_select (in_column_select),
    .in_fvf_value     (in_fvf_value),
    .in_gor_value     (in_gor_value),
    .in_visc_value    (in_visc_value),
    .in_zfac_value    (in_zfac_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  plti_lookup_monitor #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_lookup_monitor (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_opcode           (in_opcode),
    .in_entry_index      (in_entry_index),
    .in_pressure         (in_pressure),
    .in_column_select    (in_column_select),
    .in_fvf_value        (in_fvf_value),
    .in_gor_value        (in_gor_value),
    .in_visc_value       (in_visc_value),
    .in_zfac_value       (in_zfac_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_result_value    (out_result_value),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .pready              (pready),
    .mismatch_count      (mismatch_count),
    .outstanding_lookups (outstanding_lookups)
  );

  // 100 MHz clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin : receiver
    int stall_left;
    int holds_seen;
    stall_left = 0;
    holds_seen = 0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ready <= 1'b0;
      end else if (holds_seen != hold_requests) begin
        holds_seen = hold_requests;
        stall_left = LONG_HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Ends the run when no transaction of any kind happens for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("ERROR: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // Property value with extra weight on the signed extremes.
  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Query pressure aimed at the keys of the first m entries.
  function automatic logic [KEY_W-1:0] pick_query(input int m);
    int i;
    int v;
    if (m == 0) return KEY_W'($urandom);
    i = $urandom_range(0, m - 1);
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = KEY_MAX;
      2: v = tbl_key[0];
      3: v = tbl_key[m-1];
      4: v = tbl_key[i];
      5: v = tbl_key[0] - 1;
      6: v = $urandom_range(0, KEY_MAX);
      default: begin
        if (i < m - 1 && tbl_key[i+1] > tbl_key[i])
          v = tbl_key[i] + $urandom_range(0, tbl_key[i+1] - tbl_key[i] - 1);
        else
          v = tbl_key[i] + 1;
      end
    endcase
    if (v < 0) v = 0;
    if (v > KEY_MAX) v = KEY_MAX;
    return v[KEY_W-1:0];
  endfunction

  // Offer one input transaction and wait for it to be taken.
  task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
                           input logic [KEY_W-1:0] p, input logic [COL_W-1:0] col,
                           input logic [VAL_W-1:0] fvf, input logic [VAL_W-1:0] gor,
                           input logic [VAL_W-1:0] visc, input logic [VAL_W-1:0] zfac);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_opcode        <= op;
    in_entry_index   <= idx;
    in_pressure      <= p;
    in_column_select <= col;
    in_fvf_value     <= fvf;
    in_gor_value     <= gor;
    in_visc_value    <= visc;
    in_zfac_value    <= zfac;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (op == OP_WRITE) begin
      writes_sent++;
      tbl_key[idx] = int'(p);
    end else begin
      lookups_sent++;
    end
  endtask

  task automatic write_entry(input logic [IDX_W-1:0] idx, input logic [KEY_W-1:0] key);
    send_item(OP_WRITE, idx, key, COL_W'($urandom), rand_value(), rand_value(),
              rand_value(), rand_value());
  endtask

  // Lookup with noise in the fields that a lookup ignores.
  task automatic lookup(input logic [KEY_W-1:0] p, input logic [COL_W-1:0] col);
    send_item(OP_LOOKUP, IDX_W'($urandom), p, col, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Drop valid, wait until every lookup has returned, then let the block go quiet.
  // It waits on the clock before polling, so that the monitor has counted the last lookup taken.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding_lookups != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write of the entry count: setup cycle, then access cycle.
  task automatic set_entry_count(input int n);
    logic [PDATA_W-1:0] word;
    word = $urandom;
    word[CNT_W-1:0] = n[CNT_W-1:0];
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_ENTRY_COUNT;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_made++;
  endtask

  // Fill entries 0..m-1 with non-decreasing keys, now and then with one pair swapped, in index or shuffled order.
  task automatic load_table(input int m);
    int order [TABLE_DEPTH];
    int keys  [TABLE_DEPTH];
    int base;
    int smax;
    int i;
    int j;
    int tmp;
    if (m == 0) return;
    base = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 65536);
    smax = (KEY_MAX - base) / m;
    if ($urandom_range(0, 2) == 0 && smax > 64) smax = 64;
    if (smax < 1) smax = 1;
    for (i = 0; i < m; i++) begin
      keys[i]  = base;
      order[i] = i;
      if ($urandom_range(0, 11) != 0) base += $urandom_range(1, smax);
      if (base > KEY_MAX) base = KEY_MAX;
    end
    // Now and then break the ascending order.
    if (m > 1 && $urandom_range(0, 7) == 0) begin
      i = $urandom_range(0, m - 1);
      j = $urandom_range(0, m - 1);
      tmp = keys[i];
      keys[i] = keys[j];
      keys[j] = tmp;
    end
    if ($urandom_range(0, 1) == 0) begin
      for (i = m - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
    end
    for (i = 0; i < m; i++) write_entry(IDX_W'(order[i]), KEY_W'(keys[order[i]]));
  endtask

  // Main stimulus and verdict.
  initial begin : stimulus
    int n;
    int m;
    int k;
    int phase;
    int c;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_opcode        = OP_WRITE;
    in_entry_index   = '0;
    in_pressure      = '0;
    in_column_select = COL_FVF;
    in_fvf_value     = '0;
    in_gor_value     = '0;
    in_visc_value    = '0;
    in_zfac_value    = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    idle_en          = 1'b1;
    hold_requests    = 0;
    items_sent       = 0;
    writes_sent      = 0;
    lookups_sent     = 0;
    settings_made    = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table after reset answers zero.
    lookup(24'hFFFFFF, COL_FVF);
    lookup(24'h000000, COL_ZFAC);

    // Extreme keys and values, including the highest index.
    send_item(OP_WRITE, 6'd0, 24'h000000, COL_FVF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h0000_0000, 32'hFFFF_FFFF);
    send_item(OP_WRITE, 6'd1, 24'hFFFFFF, COL_ZFAC, 32'h7FFF_FFFF, 32'h8000_0000,
              32'hFFFF_FFFF, 32'h0000_0001);
    send_item(OP_WRITE, 6'd63, 24'hFFFFFF, COL_GOR, 32'hFFFF_FFFF, 32'h0000_0000,
              32'h8000_0000, 32'h7FFF_FFFF);

    // Single entry: every query clamps to it.
    settle();
    set_entry_count(1);
    lookup(24'h000001, COL_GOR);
    lookup(24'h000000, COL_FVF);

    // Two entries spanning the full key range: clamps and full-swing interpolation.
    settle();
    set_entry_count(2);
    lookup(24'h000000, COL_VISC);
    lookup(24'hFFFFFF, COL_GOR);
    for (c = 0; c < 4; c++) lookup(24'h7FFFFF, c[COL_W-1:0]);
    lookup(24'h000001, COL_FVF);
    lookup(24'hFFFFFE, COL_GOR);

    // Duplicate and descending keys in the middle of the table.
    write_entry(6'd1, 24'h001000);
    write_entry(6'd2, 24'h001000);
    write_entry(6'd3, 24'h000800);
    write_entry(6'd4, 24'h002000);
    settle();
    set_entry_count(5);
    lookup(24'h001000, COL_FVF);
    lookup(24'h000C00, COL_GOR);
    lookup(24'h001800, COL_VISC);

    // Random phases: load a table, set the count, run lookups with a few stray writes.
    phase = 0;
    while (items_sent < TARGET_ITEMS) begin
      if (items_sent >= QUIET_AFTER) idle_en <= 1'b0;
      case (phase)
        0: n = 127;
        1: n = 0;
        2: n = TABLE_DEPTH;
        default: begin
          case ($urandom_range(0, 11))
            0:       n = 0;
            1:       n = 1;
            2:       n = 2;
            3:       n = TABLE_DEPTH;
            4:       n = $urandom_range(TABLE_DEPTH + 1, 127);
            default: n = $urandom_range(3, TABLE_DEPTH - 1);
          endcase
        end
      endcase
      m = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
      load_table(m);
      settle();
      set_entry_count(n);
      // One long result-side hold-off while lookups keep coming.
      if (phase == 2) hold_requests <= hold_requests + 1;
      k = $urandom_range(8, 30);
      repeat (k) begin
        if ($urandom_range(0, 11) == 0)
          write_entry(IDX_W'($urandom_range(0, TABLE_DEPTH - 1)),
                      KEY_W'($urandom_range(0, KEY_MAX)));
        else
          lookup(pick_query(m), COL_W'($urandom_range(0, 3)));
      end
      settle();
      phase++;
    end

    $display("Summary: %0d table writes and %0d lookups over %0d entry count settings,",
             writes_sent, lookups_sent, settings_made);
    $display("         from empty and single-entry tables to full and saturated counts.");
    if (mismatch_count == 0 && outstanding_lookups == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/plti_pkg.sv
sv/plti_ctrl.sv
sv/plti_datapath.sv
sv/piecewise_linear_table_interpolator_core.sv
bench/plti_lookup_monitor.sv
bench/tb_piecewise_linear_table_interpolator_core.sv
